FILE: design/scba_pkg.sv
// scba_pkg: shared types and constants of the size-class block allocator
// no dependencies; used by scba_class_sel and size_class_block_allocator
package scba_pkg;

    // number of block size registers and width of fixed fields
    localparam int REG_COUNT   = 4;
    localparam int BYTES_W     = 16;
    localparam int ROUND_W     = BYTES_W + 1;
    localparam int BLK_W       = 6;
    localparam int CLS_W       = 2;
    localparam int CFG_IDX_W   = 4;
    localparam int ALIGN_BYTES = 8;

    localparam logic [BYTES_W-1:0] RESET_BYTES [REG_COUNT] =
        '{16'd4096, 16'd8192, 16'd16384, 16'd32768};

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_TOO_LARGE  = 2'd1,
        ST_POOL_EMPTY = 2'd2,
        ST_STACK_FULL = 2'd3
    } status_t;

    typedef enum logic {
        ACT_ALLOC = 1'b0,
        ACT_FREE  = 1'b1
    } action_t;

    // result of size class lookup
    typedef struct packed {
        logic             hit;
        logic [CLS_W-1:0] cls;
    } class_sel_t;

endpackage

FILE: design/scba_class_sel.sv
// scba_class_sel: rounds a byte size up to the alignment and picks the first fitting class
// depends on scba_pkg
module scba_class_sel #(
    parameter int ACTIVE = 4
) (
    input  logic [scba_pkg::BYTES_W-1:0] request_bytes,
    input  logic [scba_pkg::BYTES_W-1:0] block_bytes [scba_pkg::REG_COUNT],
    output scba_pkg::class_sel_t         sel
);

    localparam logic [scba_pkg::ROUND_W-1:0] ALIGN_MASK =
        scba_pkg::ROUND_W'(scba_pkg::ALIGN_BYTES - 1);

    logic [scba_pkg::ROUND_W-1:0] rounded;

    // kept at 17 bits so the top few sizes round past every class
    assign rounded = ({1'b0, request_bytes} + ALIGN_MASK) & ~ALIGN_MASK;

    always_comb
    begin
        sel.hit = 1'b0;
        sel.cls = '0;
        // scan from the top so the lowest fitting class wins
        for (int c = scba_pkg::REG_COUNT - 1; c >= 0; c--)
        begin
            if (c < ACTIVE && {1'b0, block_bytes[c]} >= rounded)
            begin
                sel.hit = 1'b1;
                sel.cls = scba_pkg::CLS_W'(c);
            end
        end
    end

endmodule

FILE: design/size_class_block_allocator.sv
// size_class_block_allocator: top level, per-class LIFO free stacks in one block memory
// depends on scba_pkg and scba_class_sel
//
// a request passes the input register, then the result register, before its result is valid
// throughput: one request per cycle; the stack memory takes one write or one read per cycle
// a stalled result holds both stages, so in_ready follows out_ready when both are full
// reset: block sizes return to 4096/8192/16384/32768, every class holds all of its blocks;
//   no clearing pass, a per-class low-water mark tells untouched stack slots apart
module size_class_block_allocator #(
    parameter int NUM_CLASSES      = 4,
    parameter int BLOCKS_PER_CLASS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,

    // request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           action,
    input  logic [scba_pkg::BYTES_W-1:0]   request_bytes,
    input  logic [scba_pkg::BLK_W-1:0]     freed_block,

    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [scba_pkg::CLS_W-1:0]     size_class,
    output logic [scba_pkg::BLK_W-1:0]     block_index,

    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [scba_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [scba_pkg::BYTES_W-1:0]   cfg_data
);

    // only four size registers exist, so at most four classes take part
    localparam int ACTIVE = (NUM_CLASSES < scba_pkg::REG_COUNT) ?
                            NUM_CLASSES : scba_pkg::REG_COUNT;
    localparam int DEPTH  = ACTIVE * BLOCKS_PER_CLASS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PTR_W  = $clog2(BLOCKS_PER_CLASS);
    localparam int CNT_W  = $clog2(BLOCKS_PER_CLASS + 1);

    localparam logic [CNT_W-1:0]  CNT_FULL   = CNT_W'(BLOCKS_PER_CLASS);
    localparam logic [ADDR_W-1:0] CLASS_SPAN = ADDR_W'(BLOCKS_PER_CLASS);

    // ------------------------------------------------------------------
    // configuration registers: always ready, writes past the list ignored
    // ------------------------------------------------------------------
    logic [scba_pkg::BYTES_W-1:0] block_bytes_reg [scba_pkg::REG_COUNT];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < scba_pkg::REG_COUNT; r++)
            begin
                block_bytes_reg[r] <= scba_pkg::RESET_BYTES[r];
            end
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int r = 0; r < scba_pkg::REG_COUNT; r++)
            begin
                if (cfg_index == scba_pkg::CFG_IDX_W'(r))
                begin
                    block_bytes_reg[r] <= cfg_data;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: input register feeds result register
    // ------------------------------------------------------------------
    logic                         in_valid_reg, in_valid_next;
    logic                         action_reg;
    logic [scba_pkg::BYTES_W-1:0] req_reg;
    logic [scba_pkg::BLK_W-1:0]   blk_reg;

    logic                         out_valid_reg, out_valid_next;
    logic                         advance;
    logic                         fire;

    // the result stage moves when it is empty or its transfer completes
    assign advance  = !out_valid_reg || out_ready;
    assign fire     = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    assign in_valid_next  = in_ready ? in_valid : in_valid_reg;
    assign out_valid_next = fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request payload, loaded on every input transfer
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            action_reg <= action;
            req_reg    <= request_bytes;
            blk_reg    <= freed_block;
        end
    end

    // ------------------------------------------------------------------
    // class lookup on the registered request
    // ------------------------------------------------------------------
    scba_pkg::class_sel_t sel;

    scba_class_sel #(
        .ACTIVE (ACTIVE)
    ) u_class_sel (
        .request_bytes (req_reg),
        .block_bytes   (block_bytes_reg),
        .sel           (sel)
    );

    // ------------------------------------------------------------------
    // per-class fill count and low-water mark
    // a slot below the lowest count ever reached was never pushed to,
    // so its own position is returned in place of the memory contents
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] count_reg [ACTIVE];
    logic [CNT_W-1:0] low_reg   [ACTIVE];

    logic [CNT_W-1:0]  cnt_cur;
    logic [CNT_W-1:0]  low_cur;
    logic [CNT_W-1:0]  cnt_dec;
    logic [PTR_W-1:0]  pop_ptr;
    logic [PTR_W-1:0]  push_ptr;
    logic [ADDR_W-1:0] class_base;
    logic              do_pop;
    logic              do_push;
    scba_pkg::status_t status_calc;

    always_comb
    begin
        cnt_cur = '0;
        low_cur = '0;
        for (int c = 0; c < ACTIVE; c++)
        begin
            if (sel.cls == scba_pkg::CLS_W'(c))
            begin
                cnt_cur = count_reg[c];
                low_cur = low_reg[c];
            end
        end
    end

    assign cnt_dec    = cnt_cur - CNT_W'(1);
    assign pop_ptr    = PTR_W'(cnt_dec);
    assign push_ptr   = PTR_W'(cnt_cur);
    assign class_base = ADDR_W'(sel.cls) * CLASS_SPAN;

    always_comb
    begin
        do_pop      = 1'b0;
        do_push     = 1'b0;
        status_calc = scba_pkg::ST_OK;
        if (!sel.hit)
        begin
            status_calc = scba_pkg::ST_TOO_LARGE;
        end
        else if (action_reg == scba_pkg::ACT_ALLOC)
        begin
            if (cnt_cur == '0)
            begin
                status_calc = scba_pkg::ST_POOL_EMPTY;
            end
            else
            begin
                do_pop = 1'b1;
            end
        end
        else
        begin
            if (cnt_cur == CNT_FULL)
            begin
                status_calc = scba_pkg::ST_STACK_FULL;
            end
            else
            begin
                do_push = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < ACTIVE; c++)
            begin
                count_reg[c] <= CNT_FULL;
                low_reg[c]   <= CNT_FULL;
            end
        end
        else if (fire)
        begin
            for (int c = 0; c < ACTIVE; c++)
            begin
                if (sel.cls == scba_pkg::CLS_W'(c))
                begin
                    if (do_pop)
                    begin
                        count_reg[c] <= cnt_dec;
                        if (cnt_dec < low_cur)
                        begin
                            low_reg[c] <= cnt_dec;
                        end
                    end
                    else if (do_push)
                    begin
                        count_reg[c] <= cnt_cur + CNT_W'(1);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stack memory: one push write or one pop read per cycle
    // ------------------------------------------------------------------
    logic [scba_pkg::BLK_W-1:0] stack_mem [DEPTH];
    logic [scba_pkg::BLK_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (fire && do_push)
        begin
            stack_mem[class_base + ADDR_W'(push_ptr)] <= blk_reg;
        end
        if (fire && do_pop)
        begin
            rd_data_reg <= stack_mem[class_base + ADDR_W'(pop_ptr)];
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    logic [1:0]                 status_reg;
    logic [scba_pkg::CLS_W-1:0] cls_reg;
    logic                       popped_reg;
    logic                       fresh_reg;
    logic [scba_pkg::BLK_W-1:0] fresh_val_reg;

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            status_reg    <= status_calc;
            cls_reg       <= sel.cls;
            popped_reg    <= do_pop;
            // slot never pushed since reset: return its position
            fresh_reg     <= (CNT_W'(pop_ptr) < low_cur);
            fresh_val_reg <= scba_pkg::BLK_W'(pop_ptr);
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign size_class  = cls_reg;
    assign block_index = !popped_reg ? '0 : (fresh_reg ? fresh_val_reg : rd_data_reg);

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// testbench for size_class_block_allocator: directed and random requests checked against
// a per-class free stack predictor, with bursty sender, stalling receiver and register phases
// depends on scba_pkg and the size_class_block_allocator rtl
module testbench;

    localparam int NUM_CLASSES      = 4;
    localparam int BLOCKS_PER_CLASS = 64;
    // only four block size registers exist, so at most four classes take part
    localparam int LIVE_CLASSES     = (NUM_CLASSES < scba_pkg::REG_COUNT) ?
                                      NUM_CLASSES : scba_pkg::REG_COUNT;
    // two pipeline stages plus margin
    localparam int SETTLE_CYCLES    = 6;
    localparam int CYCLE_LIMIT      = 500000;
    localparam int REPORT_LIMIT     = 10;

    localparam logic [scba_pkg::ROUND_W-1:0] ALIGN_MASK =
        scba_pkg::ROUND_W'(scba_pkg::ALIGN_BYTES - 1);

    // register indexes of the configuration channel
    localparam logic [scba_pkg::CFG_IDX_W-1:0] REG_CLASS0   = 4'd0;
    localparam logic [scba_pkg::CFG_IDX_W-1:0] REG_CLASS1   = 4'd1;
    localparam logic [scba_pkg::CFG_IDX_W-1:0] REG_CLASS2   = 4'd2;
    localparam logic [scba_pkg::CFG_IDX_W-1:0] REG_CLASS3   = 4'd3;
    // indexes with no register behind them, writes must be ignored
    localparam logic [scba_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 4'd4;
    localparam logic [scba_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 4'd15;

    typedef struct {
        scba_pkg::action_t              act;
        logic [scba_pkg::BYTES_W-1:0]   bytes;
        logic [scba_pkg::BLK_W-1:0]     blk;
    } request_t;

    typedef struct {
        scba_pkg::status_t              code;
        logic [scba_pkg::CLS_W-1:0]     cls;
        logic [scba_pkg::BLK_W-1:0]     blk_idx;
    } outcome_t;

    typedef enum int {
        RX_ALWAYS,
        RX_COIN,
        RX_ONE_IN_FOUR,
        RX_MOSTLY
    } rx_mode_t;

    // dut signals, all inputs known from time zero
    logic                             clk           = 1'b0;
    logic                             rst_n         = 1'b0;
    logic                             in_valid      = 1'b0;
    logic                             in_ready;
    logic                             action        = 1'b0;
    logic [scba_pkg::BYTES_W-1:0]     request_bytes = '0;
    logic [scba_pkg::BLK_W-1:0]       freed_block   = '0;
    logic                             out_valid;
    logic                             out_ready     = 1'b0;
    logic [1:0]                       status;
    logic [scba_pkg::CLS_W-1:0]       size_class;
    logic [scba_pkg::BLK_W-1:0]       block_index;
    logic                             cfg_valid     = 1'b0;
    logic                             cfg_ready;
    logic [scba_pkg::CFG_IDX_W-1:0]   cfg_index     = '0;
    logic [scba_pkg::BYTES_W-1:0]     cfg_data      = '0;

    // predictor state: block sizes and one lifo free stack per class
    logic [scba_pkg::BYTES_W-1:0]   model_sizes [scba_pkg::REG_COUNT];
    logic [scba_pkg::BLK_W-1:0]     model_stack [scba_pkg::REG_COUNT][BLOCKS_PER_CLASS];
    int                             model_count [scba_pkg::REG_COUNT];

    // block sizes as last written, used to aim random sizes at a class
    logic [scba_pkg::BYTES_W-1:0]   cfg_sizes   [scba_pkg::REG_COUNT];

    request_t             request_q[$];
    outcome_t             awaited_outcomes[$];

    int                   req_issued     = 0;
    int                   req_accepted   = 0;
    int                   cfg_accepted   = 0;
    int                   results_seen   = 0;
    int                   mismatch_count = 0;
    int                   settings_run   = 1;
    int                   outcome_tally [4] = '{0, 0, 0, 0};
    int                   cycle_count    = 0;

    size_class_block_allocator #(
        .NUM_CLASSES      (NUM_CLASSES),
        .BLOCKS_PER_CLASS (BLOCKS_PER_CLASS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .request_bytes (request_bytes),
        .freed_block   (freed_block),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .size_class    (size_class),
        .block_index   (block_index),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // predictor
    // ---------------------------------------------------------------

    // state right after reset: default sizes, every stack full with 0..63
    function automatic void model_reset();
        for (int c = 0; c < scba_pkg::REG_COUNT; c++)
        begin
            model_sizes[c] = scba_pkg::RESET_BYTES[c];
            cfg_sizes[c]   = scba_pkg::RESET_BYTES[c];
            model_count[c] = BLOCKS_PER_CLASS;
            for (int j = 0; j < BLOCKS_PER_CLASS; j++)
                model_stack[c][j] = scba_pkg::BLK_W'(j);
        end
    endfunction

    // one allocate or free against the predicted stacks
    function automatic outcome_t serve_request(scba_pkg::action_t act,
                                               logic [scba_pkg::BYTES_W-1:0] bytes,
                                               logic [scba_pkg::BLK_W-1:0] blk);
        logic [scba_pkg::ROUND_W-1:0] rounded;
        int                           cls;
        outcome_t                     res;
        // rounding is done at 17 bits, so the top sizes land on 65536
        rounded = ({1'b0, bytes} + ALIGN_MASK) & ~ALIGN_MASK;
        // first class whose block is large enough wins
        cls = -1;
        for (int c = LIVE_CLASSES - 1; c >= 0; c--)
            if ({1'b0, model_sizes[c]} >= rounded)
                cls = c;
        res.code    = scba_pkg::ST_OK;
        res.cls     = '0;
        res.blk_idx = '0;
        if (cls < 0)
            res.code = scba_pkg::ST_TOO_LARGE;
        else
        begin
            res.cls = scba_pkg::CLS_W'(cls);
            if (act == scba_pkg::ACT_ALLOC)
            begin
                if (model_count[cls] == 0)
                    res.code = scba_pkg::ST_POOL_EMPTY;
                else
                begin
                    model_count[cls]--;
                    res.blk_idx = model_stack[cls][model_count[cls]];
                end
            end
            else if (model_count[cls] >= BLOCKS_PER_CLASS)
                res.code = scba_pkg::ST_STACK_FULL;  // index is dropped
            else
            begin
                // duplicates are not caught, the index simply goes on top
                model_stack[cls][model_count[cls]] = blk;
                model_count[cls]++;
            end
        end
        outcome_tally[int'(res.code)]++;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    function automatic void push_request(scba_pkg::action_t act, int bytes, int blk);
        request_t r;
        r.act   = act;
        r.bytes = scba_pkg::BYTES_W'(bytes);
        r.blk   = scba_pkg::BLK_W'(blk);
        request_q.push_back(r);
    endfunction

    // random request, mostly aimed at one class so its stack can run dry or fill up
    function automatic request_t random_request(int alloc_pct, int focus);
        request_t r;
        int       pick;
        int       cls;
        int       lo;
        int       hi;
        r.act = ($urandom_range(0, 99) < alloc_pct) ? scba_pkg::ACT_ALLOC : scba_pkg::ACT_FREE;
        r.blk = scba_pkg::BLK_W'($urandom);
        pick  = $urandom_range(0, 99);
        cls   = (pick < 55) ? focus : $urandom_range(0, scba_pkg::REG_COUNT - 1);
        hi    = int'(cfg_sizes[cls]);
        // skip the sizes an earlier, smaller class would take
        lo    = (cls > 0 && cfg_sizes[cls-1] < cfg_sizes[cls]) ?
                int'(cfg_sizes[cls-1]) + 1 : 0;
        if (pick >= 94)
            r.bytes = scba_pkg::BYTES_W'($urandom);
        else if (pick >= 90)
            r.bytes = scba_pkg::BYTES_W'($urandom_range(65520, 65535));  // near the rounding wrap
        else if (pick >= 84)
            r.bytes = scba_pkg::BYTES_W'(hi + $urandom_range(0, 8));     // straddle the class limit
        else
            r.bytes = scba_pkg::BYTES_W'($urandom_range(lo, hi));
        return r;
    endfunction

    task automatic queue_random(int count, int alloc_pct, int focus);
        for (int i = 0; i < count; i++)
            request_q.push_back(random_request(alloc_pct, focus));
    endtask

    // wait at falling edges until every request is through and answered
    task automatic settle();
        while (request_q.size() != 0 || req_issued != req_accepted
               || awaited_outcomes.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one register transfer; called at a falling edge, leaves cfg_valid high
    task automatic cfg_write(logic [scba_pkg::CFG_IDX_W-1:0] idx,
                             logic [scba_pkg::BYTES_W-1:0] data);
        int target;
        target = cfg_accepted + 1;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(negedge clk);
        while (cfg_accepted != target);
    endtask

    task automatic write_block_sizes(int s0, int s1, int s2, int s3);
        cfg_write(REG_CLASS0, scba_pkg::BYTES_W'(s0));
        cfg_write(REG_CLASS1, scba_pkg::BYTES_W'(s1));
        cfg_write(REG_CLASS2, scba_pkg::BYTES_W'(s2));
        cfg_write(REG_CLASS3, scba_pkg::BYTES_W'(s3));
        cfg_valid <= 1'b0;
        cfg_sizes[0] = scba_pkg::BYTES_W'(s0);
        cfg_sizes[1] = scba_pkg::BYTES_W'(s1);
        cfg_sizes[2] = scba_pkg::BYTES_W'(s2);
        cfg_sizes[3] = scba_pkg::BYTES_W'(s3);
        settings_run++;
    endtask

    // ---------------------------------------------------------------
    // request driver: bursts of transfers with random gaps, fed from request_q
    // ---------------------------------------------------------------
    int  burst_left = 0;
    int  gap_left   = 0;
    bit  drain_hold = 1'b0;

    always @(negedge clk)
    begin : request_driver
        request_t next_req;
        if (in_valid && req_accepted != req_issued)
        begin
            // item still waiting for its transfer, hold everything
        end
        else if (drain_hold)
        begin
            // pause until every expected result is back
            in_valid <= 1'b0;
            if (awaited_outcomes.size() == 0 && req_accepted == req_issued)
                drain_hold = 1'b0;
        end
        else if (gap_left > 0)
        begin
            in_valid <= 1'b0;
            gap_left--;
        end
        else if (request_q.size() != 0)
        begin
            next_req = request_q.pop_front();
            in_valid      <= 1'b1;
            action        <= next_req.act;
            request_bytes <= next_req.bytes;
            freed_block   <= next_req.blk;
            req_issued++;
            if (burst_left > 0)
                burst_left--;
            else
            begin
                // long gapless stretches now and then, short bursts otherwise
                burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
                                                         : $urandom_range(1, 20);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
                if ($urandom_range(0, 29) == 0)
                    drain_hold = 1'b1;
            end
        end
        else
            in_valid <= 1'b0;
    end

    // ---------------------------------------------------------------
    // result receiver: ready follows a pattern that changes every so often
    // ---------------------------------------------------------------
    rx_mode_t rx_mode      = RX_ALWAYS;
    int       rx_mode_left = 0;
    int       rx_tick      = 0;

    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = rx_mode_t'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(32, 160);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            RX_ALWAYS:      out_ready <= 1'b1;
            RX_COIN:        out_ready <= ($urandom_range(0, 1) == 1);
            RX_ONE_IN_FOUR: out_ready <= (rx_tick % 4 == 0);
            default:        out_ready <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // ---------------------------------------------------------------
    // monitor: predict on request transfers, check on result transfers,
    // track register transfers; all sampled at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        outcome_t want;
        outcome_t got;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                awaited_outcomes.push_back(serve_request(scba_pkg::action_t'(action),
                                                         request_bytes, freed_block));
                req_accepted++;
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                got.code    = scba_pkg::status_t'(status);
                got.cls     = size_class;
                got.blk_idx = block_index;
                if (awaited_outcomes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result with none expected: ", $realtime,
                                 "status=%0d class=%0d block=%0d",
                                 got.code, got.cls, got.blk_idx);
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (got.code !== want.code || got.cls !== want.cls
                        || got.blk_idx !== want.blk_idx)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: result %0d mismatch: ", $realtime, results_seen,
                                     "expected status=%0d class=%0d block=%0d, ",
                                     want.code, want.cls, want.blk_idx,
                                     "got status=%0d class=%0d block=%0d",
                                     got.code, got.cls, got.blk_idx);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                // writes to indexes past the last register change nothing
                if (int'(cfg_index) < scba_pkg::REG_COUNT)
                    model_sizes[cfg_index[1:0]] = cfg_data;
                cfg_accepted++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_outcomes.size());
            $display("size_class_block_allocator verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial
    begin
        model_reset();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: size extremes, class boundaries, every status, both actions
        push_request(scba_pkg::ACT_ALLOC, 0, 0);         // smallest size, top of class 0 stack
        push_request(scba_pkg::ACT_ALLOC, 1, 63);        // rounds up to 8
        push_request(scba_pkg::ACT_ALLOC, 4096, 0);      // exact fit at class 0 limit
        push_request(scba_pkg::ACT_ALLOC, 4097, 0);      // just past it, class 1
        push_request(scba_pkg::ACT_ALLOC, 16384, 0);
        push_request(scba_pkg::ACT_ALLOC, 32768, 0);     // largest class at its limit
        push_request(scba_pkg::ACT_ALLOC, 32769, 0);     // too large
        push_request(scba_pkg::ACT_ALLOC, 65528, 0);     // largest multiple of 8, too large
        push_request(scba_pkg::ACT_ALLOC, 65529, 0);     // rounding wraps to 65536
        push_request(scba_pkg::ACT_ALLOC, 65535, 63);
        push_request(scba_pkg::ACT_FREE, 65535, 5);      // too large on free, nothing pushed
        push_request(scba_pkg::ACT_FREE, 8, 0);
        push_request(scba_pkg::ACT_FREE, 8, 63);
        push_request(scba_pkg::ACT_FREE, 8, 63);         // duplicate free goes through
        push_request(scba_pkg::ACT_FREE, 8, 42);         // class 0 stack already full
        push_request(scba_pkg::ACT_FREE, 32768, 1);
        push_request(scba_pkg::ACT_FREE, 20000, 7);      // class 3 full
        push_request(scba_pkg::ACT_ALLOC, 8, 0);         // pops the duplicate twice
        push_request(scba_pkg::ACT_ALLOC, 8, 0);
        push_request(scba_pkg::ACT_FREE, 4100, 21);
        push_request(scba_pkg::ACT_ALLOC, 8190, 0);      // gets 21 back
        push_request(scba_pkg::ACT_ALLOC, 8193, 0);

        // reset sizes, allocation heavy on class 0 until its pool runs dry
        queue_random(190, 85, 0);

        // smallest and largest sizes, plus writes to unmapped indexes
        settle();
        cfg_write(REG_SPARE_LO, 16'hFFFF);
        cfg_write(REG_SPARE_HI, 16'h0000);
        write_block_sizes(8, 16, 65535, 65535);
        queue_random(190, 40, 1);

        // first class covers every size up to 65528, later ones are shadowed
        settle();
        write_block_sizes(65535, 8, 8, 8);
        queue_random(190, 80, 0);

        // every class at the minimum, so requests land on class 0 or are too large
        settle();
        write_block_sizes(8, 8, 8, 8);
        queue_random(190, 60, 0);

        // free heavy so stacks fill up again
        settle();
        write_block_sizes(1000, 2000, 40000, 65528);
        queue_random(190, 25, 2);

        // back to the reset sizes
        settle();
        write_block_sizes(4096, 8192, 16384, 32768);
        queue_random(200, 50, 3);

        settle();
        $display("%0d requests over %0d block size settings, %0d results checked",
                 req_accepted, settings_run, results_seen);
        $display("outcomes: ok %0d, too large %0d, pool empty %0d, stack full %0d",
                 outcome_tally[scba_pkg::ST_OK], outcome_tally[scba_pkg::ST_TOO_LARGE],
                 outcome_tally[scba_pkg::ST_POOL_EMPTY], outcome_tally[scba_pkg::ST_STACK_FULL]);
        if (mismatch_count == 0 && awaited_outcomes.size() == 0)
            $display("size_class_block_allocator verification clean");
        else
            $display("size_class_block_allocator verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/scba_pkg.sv
design/scba_class_sel.sv
design/size_class_block_allocator.sv
tb/testbench.sv
